// File: sv/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge, skipped while reset is high.
`define PCR_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: assertion failed");

// Checked at every rising edge, reset included.
`define PCR_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("%m: assertion failed");

`endif

// File: sv/pcr_pkg.sv
package pcr_pkg;

   localparam int Lanes   = 8;
   localparam int UMaxOut = 255;

   localparam logic OP_WEIGHT = 1'b0;
   localparam logic OP_ACT    = 1'b1;

   typedef enum logic [2:0] {
      CSR_INPUT_GROUPS       = 3'd0,
      CSR_OUTPUT_GROUPS      = 3'd1,
      CSR_ROW_WIDTH          = 3'd2,
      CSR_SHIFT_AMOUNT       = 3'd3,
      CSR_SIGNED_ACTIVATIONS = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic        operation;
      logic [10:0] row_index;
      logic [7:0]  lane0;
      logic [7:0]  lane1;
      logic [7:0]  lane2;
      logic [7:0]  lane3;
      logic [7:0]  lane4;
      logic [7:0]  lane5;
      logic [7:0]  lane6;
      logic [7:0]  lane7;
   } req_type;

   typedef struct packed {
      logic [2:0] out_group;
      logic [7:0] out0;
      logic [7:0] out1;
      logic [7:0] out2;
      logic [7:0] out3;
      logic [7:0] out4;
      logic [7:0] out5;
      logic [7:0] out6;
      logic [7:0] out7;
      logic       last_of_pixel;
      logic       last_of_row;
   } rsp_type;

   typedef logic signed [8:0] act_type;
   typedef logic signed [7:0] wgt_type;

   typedef struct packed {
      logic       mac_en;
      logic [2:0] mac_grp;
      logic       clr_en;
      logic [2:0] rd_grp;
   } lane_ctl_type;

   typedef struct packed {
      logic       load;
      logic [2:0] grp;
      logic       last_pixel;
      logic       last_row;
   } merge_ctl_type;

endpackage

// File: sv/pointwise_conv_int8_requant.sv
// Pointwise convolution over one image row with int8 weights, int8 or uint8
// activations and uint8 outputs. The weight store is split into eight banks, one per
// input lane, so one read cycle delivers the 8x8 weights of one output-channel group to
// eight MAC lanes, each of which owns the accumulators of one output lane. A weight
// transaction is written to its bank when accepted. An activation transaction is accepted,
// then reads one bank row per output group, and the rows pass through the multiply and
// accumulate stages; after the last input group of a pixel, one result per output group
// follows at one per cycle while the result channel is not stalled. A new transaction is
// accepted while the last result still waits in the output register.
module pointwise_conv_int8_requant import pcr_pkg::*; #(
   parameter int MAX_IN_CHANNELS  = 256,
   parameter int MAX_OUT_CHANNELS = 64,
   parameter int MAX_ROW_WIDTH    = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [10:0] csr_wdata
);

   localparam int InGroupsMax   = MAX_IN_CHANNELS / Lanes;
   localparam int OutGroupsFull = MAX_OUT_CHANNELS / Lanes;
   localparam int OutGroupsMax  = (OutGroupsFull < Lanes) ? OutGroupsFull : Lanes;
   localparam int StoreDepth    = OutGroupsFull * MAX_IN_CHANNELS;
   localparam int BankDepth     = StoreDepth / Lanes;
   localparam int BankAw        = (BankDepth > 1) ? $clog2(BankDepth) : 1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MAC,
      ST_DRAIN,
      ST_OUT
   } state_type;

   logic [5:0]  in_groups_ff;
   logic [3:0]  out_groups_ff;
   logic [10:0] row_width_ff;
   logic [4:0]  shift_ff;
   logic        signed_act_ff;

   logic [5:0]  ig;
   logic [3:0]  og;
   logic [10:0] rw;
   logic [5:0]  grp_sel;

   state_type        state_ff, state_in;
   logic [5:0]       grp_cnt_ff, grp_cnt_in;
   logic [10:0]      pix_cnt_ff, pix_cnt_in;
   logic [2:0]       o_ff, o_in;
   logic [BankAw-1:0] addr_ff, addr_in;
   logic             rd_vld_ff, rd_vld_in;
   logic [2:0]       rd_grp_ff, rd_grp_in;
   logic             row_end_ff, row_end_in;
   act_type          act_ff [Lanes];
   act_type          act_in [Lanes];

   logic [7:0]    req_lane [Lanes];
   logic          accept;
   logic          wr_en;
   logic          ram_re;
   logic          out_ready;
   logic          last_o;
   lane_ctl_type  lane_ctl;
   merge_ctl_type merge_ctl;
   logic [63:0]   bank_rd [Lanes];
   wgt_type       lane_wgt [Lanes][Lanes];
   logic [31:0]   lane_acc [Lanes];

   always_ff @(posedge clock) begin
      if (reset) begin
         in_groups_ff  <= 6'd2;
         out_groups_ff <= 4'd1;
         row_width_ff  <= 11'd32;
         shift_ff      <= 5'd10;
         signed_act_ff <= 1'b1;
      end else if (csr_we) begin
         case (csr_index)
            CSR_INPUT_GROUPS:       in_groups_ff  <= csr_wdata[5:0];
            CSR_OUTPUT_GROUPS:      out_groups_ff <= csr_wdata[3:0];
            CSR_ROW_WIDTH:          row_width_ff  <= csr_wdata;
            CSR_SHIFT_AMOUNT:       shift_ff      <= csr_wdata[4:0];
            CSR_SIGNED_ACTIVATIONS: signed_act_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (in_groups_ff == 6'd0) begin
         ig = 6'd1;
      end else if (in_groups_ff > InGroupsMax) begin
         ig = 6'(InGroupsMax);
      end else begin
         ig = in_groups_ff;
      end
      if (out_groups_ff == 4'd0) begin
         og = 4'd1;
      end else if (out_groups_ff > OutGroupsMax) begin
         og = 4'(OutGroupsMax);
      end else begin
         og = out_groups_ff;
      end
      if (row_width_ff == 11'd0) begin
         rw = 11'd1;
      end else if (row_width_ff > MAX_ROW_WIDTH) begin
         rw = 11'(MAX_ROW_WIDTH);
      end else begin
         rw = row_width_ff;
      end
      grp_sel = (grp_cnt_ff < ig) ? grp_cnt_ff : ig - 6'd1;
   end

   assign req_lane[0] = req_data.lane0;
   assign req_lane[1] = req_data.lane1;
   assign req_lane[2] = req_data.lane2;
   assign req_lane[3] = req_data.lane3;
   assign req_lane[4] = req_data.lane4;
   assign req_lane[5] = req_data.lane5;
   assign req_lane[6] = req_data.lane6;
   assign req_lane[7] = req_data.lane7;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign wr_en     = accept && (req_data.operation == OP_WEIGHT)
                      && (req_data.row_index < StoreDepth);
   assign out_ready = !rsp_valid || !rsp_stall;
   assign last_o    = ({1'b0, o_ff} + 4'd1) == og;

   always_comb begin
      state_in   = state_ff;
      grp_cnt_in = grp_cnt_ff;
      pix_cnt_in = pix_cnt_ff;
      o_in       = o_ff;
      addr_in    = addr_ff;
      rd_vld_in  = 1'b0;
      rd_grp_in  = rd_grp_ff;
      row_end_in = row_end_ff;
      act_in     = act_ff;
      ram_re     = 1'b0;
      merge_ctl  = '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_data.operation == OP_ACT)) begin
               for (int k = 0; k < Lanes; k++) begin
                  act_in[k] = signed_act_ff ? {req_lane[k][7], req_lane[k]}
                                            : {1'b0, req_lane[k]};
               end
               addr_in  = BankAw'(grp_sel);
               o_in     = 3'd0;
               state_in = ST_MAC;
            end
         end
         ST_MAC: begin
            ram_re    = 1'b1;
            rd_vld_in = 1'b1;
            rd_grp_in = o_ff;
            addr_in   = addr_ff + BankAw'(ig);
            o_in      = o_ff + 3'd1;
            if (last_o) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!rd_vld_ff) begin
               if ((7'(grp_cnt_ff) + 7'd1) < 7'(ig)) begin
                  grp_cnt_in = grp_cnt_ff + 6'd1;
                  state_in   = ST_IDLE;
               end else begin
                  grp_cnt_in = 6'd0;
                  row_end_in = (12'(pix_cnt_ff) + 12'd1) >= 12'(rw);
                  pix_cnt_in = row_end_in ? 11'd0 : pix_cnt_ff + 11'd1;
                  o_in       = 3'd0;
                  state_in   = ST_OUT;
               end
            end
         end
         ST_OUT: begin
            if (out_ready) begin
               merge_ctl.load       = 1'b1;
               merge_ctl.grp        = o_ff;
               merge_ctl.last_pixel = last_o;
               merge_ctl.last_row   = last_o && row_end_ff;
               o_in                 = o_ff + 3'd1;
               if (last_o) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      lane_ctl.mac_en  = rd_vld_ff;
      lane_ctl.mac_grp = rd_grp_ff;
      lane_ctl.clr_en  = merge_ctl.load;
      lane_ctl.rd_grp  = o_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         grp_cnt_ff <= '0;
         pix_cnt_ff <= '0;
         o_ff       <= '0;
         rd_vld_ff  <= 1'b0;
         row_end_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         grp_cnt_ff <= grp_cnt_in;
         pix_cnt_ff <= pix_cnt_in;
         o_ff       <= o_in;
         rd_vld_ff  <= rd_vld_in;
         row_end_ff <= row_end_in;
      end
      addr_ff   <= addr_in;
      rd_grp_ff <= rd_grp_in;
      act_ff    <= act_in;
   end

   for (genvar b = 0; b < Lanes; b++) begin : g_bank
      pcr_ram #(
         .Width (64),
         .Depth (BankDepth)
      ) u_bank (
         .clock (clock),
         .we    (wr_en && (req_data.row_index[2:0] == 3'(b))),
         .waddr (BankAw'(req_data.row_index >> 3)),
         .wdata ({req_data.lane7, req_data.lane6, req_data.lane5, req_data.lane4,
                  req_data.lane3, req_data.lane2, req_data.lane1, req_data.lane0}),
         .re    (ram_re),
         .raddr (addr_ff),
         .rdata (bank_rd[b])
      );
   end

   for (genvar j = 0; j < Lanes; j++) begin : g_lane
      for (genvar i = 0; i < Lanes; i++) begin : g_col
         assign lane_wgt[j][i] = bank_rd[i][8*j +: 8];
      end

      pcr_lane #(
         .Depth (OutGroupsMax)
      ) u_lane (
         .clock  (clock),
         .reset  (reset),
         .ctl    (lane_ctl),
         .act    (act_ff),
         .wgt    (lane_wgt[j]),
         .acc_rd (lane_acc[j])
      );
   end

   pcr_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .ctl       (merge_ctl),
      .shift     (shift_ff),
      .acc       (lane_acc),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// File: sv/pcr_ram.sv
module pcr_ram #(
   parameter int Width = 64,
   parameter int Depth = 256,
   localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AddrW-1:0] waddr,
   input  logic [Width-1:0] wdata,
   input  logic             re,
   input  logic [AddrW-1:0] raddr,
   output logic [Width-1:0] rdata
);

   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: sv/pcr_lane.sv
module pcr_lane import pcr_pkg::*; #(
   parameter int Depth = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  lane_ctl_type ctl,
   input  act_type      act [Lanes],
   input  wgt_type      wgt [Lanes],
   output logic [31:0]  acc_rd
);

   localparam int GrpW = (Depth > 1) ? $clog2(Depth) : 1;

   logic signed [16:0] prod_ff [Lanes];
   logic signed [16:0] prod_in [Lanes];
   logic               prod_vld_ff;
   logic [GrpW-1:0]    prod_grp_ff;
   logic [31:0]        acc_ff [Depth];
   logic [31:0]        acc_in [Depth];
   logic signed [19:0] sum;

   always_comb begin
      for (int i = 0; i < Lanes; i++) begin
         prod_in[i] = act[i] * wgt[i];
      end
      sum = '0;
      for (int i = 0; i < Lanes; i++) begin
         sum = sum + 20'(prod_ff[i]);
      end
      acc_in = acc_ff;
      if (prod_vld_ff) begin
         acc_in[prod_grp_ff] = acc_ff[prod_grp_ff] + 32'(sum);
      end
      if (ctl.clr_en) begin
         acc_in[ctl.rd_grp[GrpW-1:0]] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
         for (int d = 0; d < Depth; d++) begin
            acc_ff[d] <= '0;
         end
      end else begin
         prod_vld_ff <= ctl.mac_en;
         acc_ff      <= acc_in;
      end
      if (ctl.mac_en) begin
         prod_ff     <= prod_in;
         prod_grp_ff <= ctl.mac_grp[GrpW-1:0];
      end
   end

   assign acc_rd = acc_ff[ctl.rd_grp[GrpW-1:0]];

endmodule

// File: sv/pcr_merge.sv
module pcr_merge import pcr_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  merge_ctl_type ctl,
   input  logic [4:0]    shift,
   input  logic [31:0]   acc [Lanes],
   input  logic          rsp_stall,
   output logic          rsp_valid,
   output rsp_type       rsp_data
);

   // Round half up, arithmetic shift, then clamp to the unsigned byte range.
   function automatic logic [7:0] requant(input logic [31:0] value, input logic [4:0] sh);
      logic [32:0] rnd;
      logic [32:0] total;
      logic [32:0] shifted;
      logic [7:0]  res;
      rnd     = (33'd1 << sh) >> 1;
      total   = {value[31], value} + rnd;
      shifted = total >> sh;
      if (total[32]) begin
         res = 8'd0;
      end else if (shifted > 33'(UMaxOut)) begin
         res = 8'(UMaxOut);
      end else begin
         res = shifted[7:0];
      end
      return res;
   endfunction

   rsp_type rsp_ff;
   rsp_type rsp_in;
   logic    rsp_valid_ff;
   logic    rsp_valid_in;

   always_comb begin
      rsp_in.out_group     = ctl.grp;
      rsp_in.out0          = requant(acc[0], shift);
      rsp_in.out1          = requant(acc[1], shift);
      rsp_in.out2          = requant(acc[2], shift);
      rsp_in.out3          = requant(acc[3], shift);
      rsp_in.out4          = requant(acc[4], shift);
      rsp_in.out5          = requant(acc[5], shift);
      rsp_in.out6          = requant(acc[6], shift);
      rsp_in.out7          = requant(acc[7], shift);
      rsp_in.last_of_pixel = ctl.last_pixel;
      rsp_in.last_of_row   = ctl.last_row;
      if (ctl.load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (ctl.load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: sv/pcr_checker.sv
`include "assert_macros.svh"

module pcr_checker import pcr_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input req_type     req_data,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input rsp_type     rsp_data
);

   // A stalled result transaction stays on the port unchanged.
   `PCR_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))

   `PCR_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid)

   // The end of a row is always also the end of a pixel.
   `PCR_ASSERT(a_row_in_pixel, clock, reset, rsp_valid |-> rsp_data.last_of_pixel || !rsp_data.last_of_row)

   // A weight write leaves the block free to take another request; an activation keeps the block busy.
   `PCR_ASSERT(a_weight_fast, clock, reset, req_valid && !req_stall && req_data.operation == OP_WEIGHT |=> !req_stall)
   `PCR_ASSERT(a_act_busy, clock, reset, req_valid && !req_stall && req_data.operation == OP_ACT |=> req_stall)

endmodule

bind pointwise_conv_int8_requant pcr_checker u_pcr_checker (.*);
